// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the block's RTL files.
// Depends on nothing; expects clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/csb_pkg.sv =====
// Package for the carrier-sense burst MAC: field widths, codes, shared types.
// Depends on nothing.
package csb_pkg;

	localparam int HANDLE_W = 8;
	localparam int ADDR_W   = 8;
	localparam int CMD_W    = 3;
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 2;
	localparam int FILL_W   = 5;
	localparam int DRAW_W   = 16;
	localparam int TICKS_W  = 16;
	localparam int TIMER_W  = 17;
	localparam int BURST_W  = 8;
	localparam int RXCNT_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [BURST_W-1:0] BURST_RESET = 8'd10;

	// event commands
	localparam logic [CMD_W-1:0] CMD_UPPER    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TX_END   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RX_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RX_END   = 3'd4;

	// result actions
	localparam logic [ACT_W-1:0] ACT_NONE         = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START_TX     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DELIVER      = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROP_CORRUPT = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DROP_NOTMINE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DROP_FULL    = 3'd5;

	// status codes on the result port
	localparam logic [STAT_W-1:0] STAT_IDLE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SENSE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TX    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_SENSE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SENSE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR   = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SENSE = 3'b010,
		ST_TX    = 3'b100
	} csb_state_t;

	// queue request from the controller
	typedef struct packed {
		logic                push;
		logic                pop;
		logic [HANDLE_W-1:0] data;
	} csb_qreq_t;

	// queue status toward the controller
	typedef struct packed {
		logic [FILL_W-1:0]   fill;
		logic                room;
		logic [HANDLE_W-1:0] head_data;
	} csb_qstat_t;

	// one result item
	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [HANDLE_W-1:0] handle;
		logic [ADDR_W-1:0]   source;
		logic [STAT_W-1:0]   status;
		logic [FILL_W-1:0]   count;
	} csb_result_t;

	function automatic logic [STAT_W-1:0] status_code(input csb_state_t st);
		logic [STAT_W-1:0] code;
		case (st)
			ST_IDLE:  code = STAT_IDLE;
			ST_SENSE: code = STAT_SENSE;
			ST_TX:    code = STAT_TX;
			default:  code = STAT_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/csb_queue.sv =====
// Transmit FIFO of packet handles: memory, head pointer and fill count.
// Depends on csb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csb_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [csb_pkg::FILL_W-1:0]    queue_limit,
	input  csb_pkg::csb_qreq_t            req,
	output csb_pkg::csb_qstat_t           stat
);
	import csb_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SW = ((AW > FILL_W) ? AW : FILL_W) + 1;
	localparam logic [SW-1:0] DEPTH_W = SW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);

	logic [HANDLE_W-1:0] mem [QUEUE_DEPTH];
	logic [HANDLE_W-1:0] rd_q;
	logic [AW-1:0]       head_q, head_d, tail;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic [SW-1:0]       tail_sum;

	// tail = (head + fill) mod depth; sum stays below twice the depth
	always_comb begin
		tail_sum = SW'(head_q) + SW'(fill_q);
		if (tail_sum >= DEPTH_W)
			tail_sum = tail_sum - DEPTH_W;
		tail = tail_sum[AW-1:0];
	end

	always_comb begin
		head_d = head_q;
		if (req.pop)
			head_d = (head_q == LAST) ? '0 : head_q + AW'(1);
		fill_d = fill_q + FILL_W'(req.push) - FILL_W'(req.pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			head_q <= head_d;
			fill_q <= fill_d;
		end
	end

	// one write port, one registered read port following the next head
	always_ff @(posedge clk) begin
		if (req.push)
			mem[tail] <= req.data;
	end

	always_ff @(posedge clk) begin
		if (req.push && (tail == head_d))
			rd_q <= req.data;
		else
			rd_q <= mem[head_d];
	end

	assign stat.fill      = fill_q;
	assign stat.head_data = rd_q;
	assign stat.room      = (fill_q < queue_limit) && (SW'(fill_q) < DEPTH_W);

	`CSB_ASSERT_IMPL(a_pop_nonempty, req.pop, fill_q != '0, "pop from empty queue")
	`CSB_ASSERT_IMPL(a_push_room, req.push, stat.room, "push without room")
	`CSB_ASSERT_IMPL(a_fill_bound, 1'b1, SW'(fill_q) <= DEPTH_W, "fill above depth")

endmodule

// ===== hdl/csb_ctrl.sv =====
// MAC control: status, sensing timer, burst and reception counters, result build.
// Depends on csb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  logic [csb_pkg::CMD_W-1:0]      command_s1,
	input  logic [csb_pkg::HANDLE_W-1:0]   handle_s1,
	input  logic [csb_pkg::ADDR_W-1:0]     dest_s1,
	input  logic [csb_pkg::ADDR_W-1:0]     source_s1,
	input  logic                           corrupt_s1,
	input  logic [csb_pkg::DRAW_W-1:0]     draw_s1,
	input  logic [csb_pkg::BURST_W-1:0]    max_burst,
	input  logic [csb_pkg::TICKS_W-1:0]    fixed_sense_ticks,
	input  logic [csb_pkg::TICKS_W-1:0]    random_sense_ticks,
	input  logic [csb_pkg::ADDR_W-1:0]     own_address,
	input  logic [csb_pkg::ADDR_W-1:0]     broadcast_address,
	input  csb_pkg::csb_qstat_t            qstat,
	output csb_pkg::csb_qreq_t             qreq,
	output csb_pkg::csb_result_t           result
);
	import csb_pkg::*;

	csb_state_t          state_q, state_d;
	logic [TIMER_W-1:0]  timer_q, timer_d;
	logic [BURST_W-1:0]  burst_q, burst_d, burst_inc, send_b;
	logic [RXCNT_W-1:0]  rx_q, rx_d;
	logic [2*TICKS_W-1:0] prod;
	logic [TIMER_W-1:0]  load_sum, load;
	logic                attempt;

	// sensing load: fixed + floor(draw * span / 65536), at least one tick
	always_comb begin
		prod     = (2*TICKS_W)'(draw_s1) * (2*TICKS_W)'(random_sense_ticks);
		load_sum = {1'b0, fixed_sense_ticks} + {1'b0, prod[2*TICKS_W-1:TICKS_W]};
		load     = (load_sum == '0) ? TIMER_W'(1) : load_sum;
	end

	assign burst_inc = (burst_q == '1) ? burst_q : burst_q + BURST_W'(1);

	always_comb begin
		state_d = state_q;
		timer_d = timer_q;
		burst_d = burst_q;
		rx_d    = rx_q;
		attempt = 1'b0;
		send_b  = burst_inc;
		qreq    = '0;
		qreq.data = handle_s1;
		result.action = ACT_NONE;
		result.handle = '0;
		result.source = '0;

		if (valid_s1) begin
			case (command_s1)
				CMD_UPPER: begin
					if (qstat.room) begin
						qreq.push = 1'b1;
					end else begin
						result.action = ACT_DROP_FULL;
						result.handle = handle_s1;
					end
					if (state_q == ST_IDLE) begin
						rx_d    = '0;
						state_d = ST_SENSE;
						timer_d = load;
					end
				end
				CMD_TICK: begin
					if (state_q == ST_SENSE) begin
						if (timer_q > TIMER_W'(1)) begin
							timer_d = timer_q - TIMER_W'(1);
						end else begin
							timer_d = '0;
							burst_d = '0;
							send_b  = '0;
							if (rx_q != '0) begin
								rx_d    = '0;
								timer_d = load;
							end else begin
								state_d = ST_TX;
								attempt = 1'b1;
							end
						end
					end
				end
				CMD_TX_END: begin
					if (state_q == ST_TX) begin
						burst_d = burst_inc;
						attempt = 1'b1;
					end
				end
				CMD_RX_START: begin
					if (rx_q != '1)
						rx_d = rx_q + RXCNT_W'(1);
				end
				CMD_RX_END: begin
					result.handle = handle_s1;
					result.source = source_s1;
					if (corrupt_s1)
						result.action = ACT_DROP_CORRUPT;
					else if (dest_s1 != own_address && dest_s1 != broadcast_address)
						result.action = ACT_DROP_NOTMINE;
					else
						result.action = ACT_DELIVER;
				end
				default: begin
				end
			endcase

			// send attempt: empty -> idle, room in burst -> pop, else sense anew
			if (attempt) begin
				if (qstat.fill == '0) begin
					state_d = ST_IDLE;
				end else if (send_b < max_burst) begin
					qreq.pop      = 1'b1;
					result.action = ACT_START_TX;
					result.handle = qstat.head_data;
				end else begin
					state_d = ST_SENSE;
					rx_d    = '0;
					timer_d = load;
				end
			end
		end

		result.status = status_code(state_d);
		result.count  = qstat.fill + FILL_W'(qreq.push) - FILL_W'(qreq.pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			timer_q <= '0;
			burst_q <= BURST_RESET;
			rx_q    <= '0;
		end else begin
			state_q <= state_d;
			timer_q <= timer_d;
			burst_q <= burst_d;
			rx_q    <= rx_d;
		end
	end

	`CSB_ASSERT_IMPL(a_sense_timer, state_q == ST_SENSE, timer_q != '0, "sensing with zero timer")
	`CSB_ASSERT_IMPL(a_tx_state, result.action == ACT_START_TX, state_d == ST_TX,
		"transmit start outside transmitting")
	`CSB_ASSERT_NEXT(a_idle_hold, !valid_s1, $stable(state_q) && $stable(timer_q),
		"state moved without an event")

endmodule

// ===== hdl/carrier_sense_burst_mac_top.sv =====
// Top level of the carrier-sense burst MAC: config registers, event and result registers.
// Depends on csb_pkg, csb_queue, csb_ctrl and assert_macros.svh.
//
// Usage:
// - Events enter on start with command and its fields; a transfer takes place
//   at each rising edge with start high and busy low. busy stays low, so one
//   event can be given on every clock.
// - Each event gives exactly one result: done is high for one cycle with
//   action, out_handle, out_source, status and queue_count. The receiver
//   cannot stall; results are taken as they come.
// - An event goes through the event register, then the result register that
//   drives the outputs with done. Throughput: one event per cycle. The event
//   register feeds one pass of control logic (one 16x16 multiply for the
//   sensing load, one queue access) whose state updates land by the next edge.
// - Configuration: cfg_we, cfg_index, cfg_wdata write one register per edge; the user
//   writes only while no event is in flight (unenforced). Indexes past the list are ignored.
// - Reset (arst_n low): status idle, queue empty, burst count 10, timer and
//   reception count zero, registers at their defaults. No clearing pass:
//   queue entries are only read after being written.
`include "assert_macros.svh"

module carrier_sense_burst_mac_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [csb_pkg::CMD_W-1:0]         command,
	input  logic [csb_pkg::HANDLE_W-1:0]      packet_handle,
	input  logic [csb_pkg::ADDR_W-1:0]        dest_address,
	input  logic [csb_pkg::ADDR_W-1:0]        source_address,
	input  logic                              corrupt,
	input  logic [csb_pkg::DRAW_W-1:0]        random_draw,
	input  logic                              cfg_we,
	input  logic [csb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                              done,
	output logic [csb_pkg::ACT_W-1:0]         action,
	output logic [csb_pkg::HANDLE_W-1:0]      out_handle,
	output logic [csb_pkg::ADDR_W-1:0]        out_source,
	output logic [csb_pkg::STAT_W-1:0]        status,
	output logic [csb_pkg::FILL_W-1:0]        queue_count
);
	import csb_pkg::*;

	// configuration registers
	logic [FILL_W-1:0]  queue_limit_q;
	logic [BURST_W-1:0] max_burst_q;
	logic [TICKS_W-1:0] fixed_sense_q;
	logic [TICKS_W-1:0] random_sense_q;
	logic [ADDR_W-1:0]  own_addr_q;
	logic [ADDR_W-1:0]  bcast_addr_q;

	// event register
	logic                valid_s1;
	logic [CMD_W-1:0]    command_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [ADDR_W-1:0]   dest_s1;
	logic [ADDR_W-1:0]   source_s1;
	logic                corrupt_s1;
	logic [DRAW_W-1:0]   draw_s1;

	// result register
	logic        done_q;
	csb_result_t result_c, result_q;

	csb_qreq_t  qreq;
	csb_qstat_t qstat;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q  <= FILL_W'(16);
			max_burst_q    <= BURST_W'(10);
			fixed_sense_q  <= TICKS_W'(1);
			random_sense_q <= TICKS_W'(1);
			own_addr_q     <= '0;
			bcast_addr_q   <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUEUE_LIMIT:  queue_limit_q  <= cfg_wdata[FILL_W-1:0];
				REG_MAX_BURST:    max_burst_q    <= cfg_wdata[BURST_W-1:0];
				REG_FIXED_SENSE:  fixed_sense_q  <= cfg_wdata[TICKS_W-1:0];
				REG_RANDOM_SENSE: random_sense_q <= cfg_wdata[TICKS_W-1:0];
				REG_OWN_ADDR:     own_addr_q     <= cfg_wdata[ADDR_W-1:0];
				REG_BCAST_ADDR:   bcast_addr_q   <= cfg_wdata[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// event transfer: start with busy low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			command_s1 <= command;
			handle_s1  <= packet_handle;
			dest_s1    <= dest_address;
			source_s1  <= source_address;
			corrupt_s1 <= corrupt;
			draw_s1    <= random_draw;
		end
	end

	csb_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_limit (queue_limit_q),
		.req         (qreq),
		.stat        (qstat)
	);

	csb_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.valid_s1           (valid_s1),
		.command_s1         (command_s1),
		.handle_s1          (handle_s1),
		.dest_s1            (dest_s1),
		.source_s1          (source_s1),
		.corrupt_s1         (corrupt_s1),
		.draw_s1            (draw_s1),
		.max_burst          (max_burst_q),
		.fixed_sense_ticks  (fixed_sense_q),
		.random_sense_ticks (random_sense_q),
		.own_address        (own_addr_q),
		.broadcast_address  (bcast_addr_q),
		.qstat              (qstat),
		.qreq               (qreq),
		.result             (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			result_q <= result_c;
	end

	assign done        = done_q;
	assign action      = result_q.action;
	assign out_handle  = result_q.handle;
	assign out_source  = result_q.source;
	assign status      = result_q.status;
	assign queue_count = result_q.count;

	`CSB_ASSERT_NEXT(a_one_result, valid_s1, done, "event without result")
	`CSB_ASSERT_NEXT(a_no_extra, !valid_s1, !done, "result without event")

endmodule
